@@ sv/u2rd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u2rd_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF = 32;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RADIX_W = 8;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned BASE_W  = 5;

  // Quotient bits resolved per divider cycle.
  localparam int unsigned STEP_BITS = 8;

  localparam logic [RADIX_W-1:0] LOWEST_BASE  = 8'd2;
  localparam logic [RADIX_W-1:0] HIGHEST_BASE = 8'd16;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = 8'h41;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } u2rd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } u2rd_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
    logic fetch;
    logic advance;
  } u2rd_cmd_t;

  typedef struct packed {
    logic special;
    logic pass_done;
    logic quo_zero;
    logic full;
    logic idx_zero;
  } u2rd_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_LIMIT);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/u2rd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u2rd_datapath import u2rd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire u2rd_in_t   in_i,
  input  wire u2rd_cmd_t  cmd_i,
  output u2rd_sts_t       sts_o,
  output u2rd_out_t       out_o
);

  localparam int unsigned PASSES   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_BITS = PASSES * STEP_BITS;
  localparam int unsigned PASS_W   = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int unsigned ADDR_W   = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam logic [PAD_BITS-1:0] VAL_MASK = PAD_BITS'({VALUE_BITS{1'b1}});

  logic [PAD_BITS-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [PASS_W-1:0]   pass_q, pass_d;
  logic [CNT_W-1:0]    dcnt_q, dcnt_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;
  logic [DIGIT_W-1:0]  rd_data_q;
  logic [DIGIT_W-1:0]  mem [MAX_DIGITS];

  logic [PAD_BITS-1:0]  val_masked;
  logic                 special;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W-1:0]   step_rem;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_en;

  assign val_masked = PAD_BITS'(in_i.value) & VAL_MASK;
  assign special    = (val_masked == '0) ||
                      !(in_i.radix inside {[LOWEST_BASE:HIGHEST_BASE]});

  // Restoring division, one quotient bit per inner step.
  always_comb begin
    logic [STEP_BITS-1:0] top;
    logic [BASE_W-1:0]    r;
    top = quo_q[PAD_BITS-1 -: STEP_BITS];
    r   = {1'b0, rem_q};
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], top[i]};
      if (r >= base_q) begin
        r        = r - base_q;
        qbits[i] = 1'b1;
      end else begin
        qbits[i] = 1'b0;
      end
    end
    step_rem = r[DIGIT_W-1:0];
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    base_d = base_q;
    pass_d = pass_q;
    dcnt_d = dcnt_q;
    idx_d  = idx_q;
    if (cmd_i.load) begin
      quo_d  = special ? '0 : val_masked;
      rem_d  = '0;
      base_d = in_i.radix[BASE_W-1:0];
      pass_d = '0;
      dcnt_d = '0;
    end
    if (cmd_i.step) begin
      quo_d  = (quo_q << STEP_BITS) | PAD_BITS'(qbits);
      rem_d  = step_rem;
      pass_d = pass_q + 1'b1;
    end
    if (cmd_i.store) begin
      rem_d  = '0;
      pass_d = '0;
      dcnt_d = dcnt_q + 1'b1;
    end
    if (cmd_i.fetch) begin
      idx_d = ADDR_W'(dcnt_q - 1'b1);
    end
    if (cmd_i.advance) begin
      idx_d = idx_q - 1'b1;
    end
  end

  assign rd_en   = cmd_i.fetch | cmd_i.advance;
  assign rd_addr = idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      dcnt_q <= '0;
      idx_q  <= '0;
    end else begin
      pass_q <= pass_d;
      dcnt_q <= dcnt_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    base_q <= base_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[dcnt_q[ADDR_W-1:0]] <= rem_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign sts_o.special   = special;
  assign sts_o.pass_done = (pass_q == PASS_W'(PASSES - 1));
  assign sts_o.quo_zero  = (quo_q == '0);
  assign sts_o.full      = (dcnt_q == CNT_W'(MAX_DIGITS - 1));
  assign sts_o.idx_zero  = (idx_q == '0);

  assign out_o.character = digit_char(rd_data_q);
  assign out_o.last      = (idx_q == '0);

endmodule

`default_nettype wire

@@ sv/u2rd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u2rd_ctrl import u2rd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire u2rd_sts_t  sts_i,
  output u2rd_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_STORE = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.special ? S_STORE : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.pass_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = (sts_i.quo_zero || sts_i.full) ? S_FETCH : S_DIV;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          if (sts_i.idx_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

endmodule

`default_nettype wire

@@ sv/unsigned_to_radix_digits.sv @@
// Converts an unsigned number into upper-case ASCII digits in a base from 2 to 16.
// Input channel: in_valid_i, in_stall_o and in_i (value, radix). A transfer takes
// place at a rising edge with valid high and stall low. Only the low VALUE_BITS
// bits of value are used. A zero value or a base outside 2 to 16 gives a lone '0'.
// Output channel: out_valid_o, out_stall_i and out_o (character, last). Digits come
// out most significant first, and last marks the final digit of the number.
// One number is handled at a time; in_stall_o stays high from the input transfer
// until the last digit has been taken.
// Each digit runs through the shared divider, which resolves eight quotient bits a
// cycle, and is then stored. A fetch state then reads the first digit from the
// digit memory, after which one digit leaves per cycle unless the receiver stalls.
// The lone '0' for a zero value or an invalid base skips the divider.
// When the receiver stalls, the current digit holds and the block waits.
// Reset returns the block to idle and drops any number in progress; the digit
// memory needs no clearing, as it is always written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_to_radix_digits import u2rd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire u2rd_in_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output u2rd_out_t      out_o
);

  u2rd_cmd_t cmd;
  u2rd_sts_t sts;

  u2rd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  u2rd_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_o)
  );

endmodule

`default_nettype wire
